// ----- rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define SDWR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SDWR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/sdwr_pkg.sv -----
// package: widths, stage record and status codes of the signed divider
`timescale 1ns / 1ps

package sdwr_pkg;

    localparam int DW = 64;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_ZERO_DIV = 1'b1;

    // control part of one pipeline stage
    typedef struct packed {
        logic valid;
        logic neg_q;
        logic neg_r;
        logic zero;
    } sdwr_ctrl_t;

    // data part of one pipeline stage
    typedef struct packed {
        logic [DW-1:0] rem;
        logic [DW-1:0] nq;
        logic [DW-1:0] den;
    } sdwr_data_t;

endpackage

// ----- rtl/sdwr_prep.sv -----
// input stage: operand magnitudes, sign flags and zero divisor detect
`timescale 1ns / 1ps

module sdwr_prep (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      src_valid,
    input  logic [sdwr_pkg::DW-1:0]   src_num,
    input  logic [sdwr_pkg::DW-1:0]   src_den,
    output sdwr_pkg::sdwr_ctrl_t      ctrl_out,
    output sdwr_pkg::sdwr_data_t      data_out
);
    import sdwr_pkg::*;

    sdwr_ctrl_t ctrl_reg;
    sdwr_ctrl_t ctrl_next;
    sdwr_data_t data_reg;
    sdwr_data_t data_next;

    always_comb
    begin
        ctrl_next.valid = src_valid;
        ctrl_next.neg_q = src_num[DW-1] ^ src_den[DW-1];
        ctrl_next.neg_r = src_num[DW-1];
        ctrl_next.zero  = (src_den == '0);
        data_next.rem   = '0;
        data_next.nq    = src_num[DW-1] ? (~src_num + 1'b1) : src_num;
        data_next.den   = src_den[DW-1] ? (~src_den + 1'b1) : src_den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (adv)
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign data_out = data_reg;

endmodule

// ----- rtl/sdwr_cell.sv -----
// one restoring division step: one quotient bit per cell
`timescale 1ns / 1ps

module sdwr_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  sdwr_pkg::sdwr_ctrl_t  ctrl_in,
    input  sdwr_pkg::sdwr_data_t  data_in,
    output sdwr_pkg::sdwr_ctrl_t  ctrl_out,
    output sdwr_pkg::sdwr_data_t  data_out
);
    import sdwr_pkg::*;

    sdwr_ctrl_t  ctrl_reg;
    sdwr_data_t  data_reg;
    sdwr_data_t  data_next;
    logic [DW:0]   partial;
    logic [DW+1:0] diff;
    logic          qbit;

    // shift next dividend bit into the partial remainder, trial subtract
    always_comb
    begin
        partial   = {data_in.rem, data_in.nq[DW-1]};
        diff      = {1'b0, partial} - {2'b00, data_in.den};
        qbit      = ~diff[DW+1];
        data_next.rem = qbit ? diff[DW-1:0] : partial[DW-1:0];
        data_next.nq  = {data_in.nq[DW-2:0], qbit};
        data_next.den = data_in.den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (adv)
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign data_out = data_reg;

endmodule

// ----- rtl/sdwr_fix.sv -----
// output stage: sign correction, zero divisor override, result register
`timescale 1ns / 1ps

module sdwr_fix (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  sdwr_pkg::sdwr_ctrl_t     ctrl_in,
    input  sdwr_pkg::sdwr_data_t     data_in,
    output logic                     res_valid,
    output logic [sdwr_pkg::DW-1:0]  res_quotient,
    output logic [sdwr_pkg::DW-1:0]  res_remainder,
    output logic                     res_status
);
    import sdwr_pkg::*;

    logic          valid_reg;
    logic [DW-1:0] quotient_reg;
    logic [DW-1:0] quotient_next;
    logic [DW-1:0] remainder_reg;
    logic [DW-1:0] remainder_next;
    logic          status_reg;
    logic          status_next;

    always_comb
    begin
        if (ctrl_in.zero)
        begin
            quotient_next  = '0;
            remainder_next = '0;
            status_next    = STATUS_ZERO_DIV;
        end
        else
        begin
            quotient_next  = ctrl_in.neg_q ? (~data_in.nq + 1'b1) : data_in.nq;
            remainder_next = ctrl_in.neg_r ? (~data_in.rem + 1'b1) : data_in.rem;
            status_next    = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= ctrl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            quotient_reg  <= quotient_next;
            remainder_reg <= remainder_next;
            status_reg    <= status_next;
        end
    end

    assign res_valid     = valid_reg;
    assign res_quotient  = quotient_reg;
    assign res_remainder = remainder_reg;
    assign res_status    = status_reg;

endmodule

// ----- rtl/signed_divide_with_remainder_top.sv -----
// top level: signed 64-bit divide with remainder, pipelined chain of cells
// path from input to result: prep stage register, one register per cell, fix result register
// throughput: one transaction per cycle while the output is not stalled, set by one division step per cell
// a stalled output freezes the whole chain; a one-entry skid takes one more transaction before the input stalls
// reset: asynchronous active-low, clears all valid bits and the skid entry
// no state survives between transactions, so reset needs no clearing pass
`timescale 1ns / 1ps
`include "assert_macros.svh"

module signed_divide_with_remainder_top (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [sdwr_pkg::DW-1:0]  dividend,
    input  logic [sdwr_pkg::DW-1:0]  divisor,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [sdwr_pkg::DW-1:0]  quotient,
    output logic [sdwr_pkg::DW-1:0]  remainder,
    output logic                     status
);
    import sdwr_pkg::*;

    // chain moves as one whenever the result register is free or being taken
    logic adv;
    logic in_acc;

    // skid entry: catches one transaction while the chain is frozen
    logic          skid_valid_reg;
    logic          skid_valid_next;
    logic [DW-1:0] skid_num_reg;
    logic [DW-1:0] skid_den_reg;

    // operands presented to the prep stage
    logic          src_valid;
    logic [DW-1:0] src_num;
    logic [DW-1:0] src_den;

    // stage records between cells: index 0 is the prep output
    sdwr_ctrl_t ctrl_chain [DW+1];
    sdwr_data_t data_chain [DW+1];

    assign adv      = !out_valid || !out_stall;
    assign in_stall = skid_valid_reg;
    assign in_acc   = in_valid && !skid_valid_reg;

    // the skid entry, when full, is older than anything at the input
    always_comb
    begin
        if (skid_valid_reg)
        begin
            src_valid = 1'b1;
            src_num   = skid_num_reg;
            src_den   = skid_den_reg;
        end
        else
        begin
            src_valid = in_acc;
            src_num   = dividend;
            src_den   = divisor;
        end
    end

    always_comb
    begin
        if (adv)
        begin
            skid_valid_next = 1'b0;
        end
        else
        begin
            skid_valid_next = skid_valid_reg || in_acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    // capture only when the chain is frozen and the entry is empty
    always_ff @(posedge clk)
    begin
        if (!adv && in_acc)
        begin
            skid_num_reg <= dividend;
            skid_den_reg <= divisor;
        end
    end

    sdwr_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .src_valid (src_valid),
        .src_num   (src_num),
        .src_den   (src_den),
        .ctrl_out  (ctrl_chain[0]),
        .data_out  (data_chain[0])
    );

    // one cell per quotient bit, most significant first
    for (genvar i = 0; i < DW; i++)
    begin : g_cell
        sdwr_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .ctrl_in  (ctrl_chain[i]),
            .data_in  (data_chain[i]),
            .ctrl_out (ctrl_chain[i+1]),
            .data_out (data_chain[i+1])
        );
    end

    sdwr_fix u_fix (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .ctrl_in       (ctrl_chain[DW]),
        .data_in       (data_chain[DW]),
        .res_valid     (out_valid),
        .res_quotient  (quotient),
        .res_remainder (remainder),
        .res_status    (status)
    );

    // a zero divisor always yields zero results
    `SDWR_ASSERT(a_zero_div_clears, (out_valid && status == STATUS_ZERO_DIV) |-> (quotient == '0 && remainder == '0), "zero divisor result not cleared")
    // the skid entry only fills behind a stalled result
    `SDWR_ASSERT(a_skid_fill_cause, $rose(skid_valid_reg) |-> $past(out_valid && out_stall), "skid filled without output stall")
    // while the skid entry is held, a result is waiting
    `SDWR_ASSERT_ALWAYS(a_skid_needs_result, skid_valid_reg |-> out_valid, "skid held with no result waiting")

endmodule
